@@ rtl/core/mchw_pkg.sv @@
// ----------------------------------------------------------------------------
// mchw_pkg
// shared types and constants of the multi-channel heartbeat watchdog
// ----------------------------------------------------------------------------
package mchw_pkg;

	localparam int NUM_MODULES_DEF = 16;
	localparam int MASK_W          = 16;
	localparam int IDX_IN_W        = 4;
	localparam int TIME_W          = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [TIME_W-1:0] GENERAL_TIMEOUT_RST = 32'd500;
	localparam logic [TIME_W-1:0] HOST_TIMEOUT_RST    = 32'd2000;

	// register map, index taken from paddr[2]
	localparam logic REG_GENERAL_TIMEOUT = 1'b0;
	localparam logic REG_HOST_TIMEOUT    = 1'b1;

	localparam logic CMD_HEARTBEAT = 1'b0;
	localparam logic CMD_SCAN      = 1'b1;

	typedef enum logic [1:0] {
		OP_HEARTBEAT = 2'd0,
		OP_SCAN      = 2'd1,
		OP_REPORT    = 2'd2
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [IDX_IN_W-1:0] idx;
		logic [TIME_W-1:0]   now;
	} item_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} q_status_t;

endpackage

@@ rtl/core/mchw_front.sv @@
// ----------------------------------------------------------------------------
// mchw_front
// accepts input beats, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module mchw_front #(
	parameter int NUM_MODULES = mchw_pkg::NUM_MODULES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [mchw_pkg::IDX_IN_W-1:0]  module_index,
	input  logic [mchw_pkg::TIME_W-1:0]    now_ms,
	input  mchw_pkg::q_status_t            q_status,
	output logic                           push,
	output mchw_pkg::item_t                push_item
);
	import mchw_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  accept;

	assign in_stall  = valid_s1 && q_status.full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_status.full;
	assign push_item = item_s1;

	// out-of-range heartbeats still report the mask but write nothing
	always_comb begin
		item_d.idx = module_index;
		item_d.now = now_ms;
		if (cmd == CMD_SCAN) begin
			item_d.op = OP_SCAN;
		end else if (32'(module_index) < 32'(NUM_MODULES)) begin
			item_d.op = OP_HEARTBEAT;
		end else begin
			item_d.op = OP_REPORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/core/mchw_queue.sv @@
// ----------------------------------------------------------------------------
// mchw_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module mchw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mchw_pkg::item_t     push_item,
	input  logic                pop,
	output mchw_pkg::item_t     pop_item,
	output mchw_pkg::q_status_t q_status
);
	import mchw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_status.nonempty = (count_q != '0);
	assign q_status.full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push           = push && !q_status.full;
	assign do_pop            = pop && q_status.nonempty;
	assign pop_item          = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/core/mchw_back.sv @@
// ----------------------------------------------------------------------------
// mchw_back
// stamp memory, scan sequencer with one subtractor, result register
// ----------------------------------------------------------------------------
module mchw_back #(
	parameter int NUM_MODULES = mchw_pkg::NUM_MODULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mchw_pkg::q_status_t           q_status,
	input  mchw_pkg::item_t               pop_item,
	output logic                          pop,
	input  logic [mchw_pkg::TIME_W-1:0]   general_timeout,
	input  logic [mchw_pkg::TIME_W-1:0]   host_timeout,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mchw_pkg::MASK_W-1:0]   offline_mask
);
	import mchw_pkg::*;

	localparam int IDX_W  = $clog2(NUM_MODULES);
	localparam int SHOW_W = (NUM_MODULES < MASK_W) ? NUM_MODULES : MASK_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MODULES - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic [TIME_W-1:0]      scan_now_q;
	logic [TIME_W-1:0]      stamp_mem [NUM_MODULES];
	logic [NUM_MODULES-1:0] stamp_vld_q;
	logic [NUM_MODULES-1:0] flags_q;
	logic [NUM_MODULES-1:0] flags_d;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [TIME_W-1:0]      rd_data_s1;
	logic                   rd_hit_s1;
	logic [TIME_W-1:0]      stamp;
	logic [TIME_W-1:0]      delta;
	logic [TIME_W-1:0]      limit;
	logic                   out_valid_q;
	logic [MASK_W-1:0]      offline_mask_q;
	logic                   out_free;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic                   rd_en;

	assign out_valid    = out_valid_q;
	assign offline_mask = offline_mask_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign pop          = (state_q == ST_IDLE) && q_status.nonempty && out_free;
	assign wr_en        = pop && (pop_item.op == OP_HEARTBEAT);
	assign wr_addr      = IDX_W'(pop_item.idx);
	assign rd_en        = (state_q == ST_SCAN);

	// never-written stamps read as zero
	assign stamp = rd_hit_s1 ? rd_data_s1 : '0;
	assign delta = scan_now_q - stamp;
	assign limit = (rd_idx_s1 == LAST_IDX) ? host_timeout : general_timeout;

	always_comb begin
		flags_d = flags_q;
		if (rd_valid_s1) begin
			flags_d[rd_idx_s1] = (delta > limit);
		end
	end

	function automatic logic [MASK_W-1:0] show_mask(input logic [NUM_MODULES-1:0] f);
		logic [MASK_W-1:0] m;
		m = '0;
		m[SHOW_W-1:0] = f[SHOW_W-1:0];
		return m;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr] <= pop_item.now;
		end
		if (rd_en) begin
			rd_data_s1 <= stamp_mem[scan_idx_q];
			rd_hit_s1  <= stamp_vld_q[scan_idx_q];
			rd_idx_s1  <= scan_idx_q;
		end
		if (pop && (pop_item.op == OP_SCAN)) begin
			scan_now_q <= pop_item.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			stamp_vld_q <= '0;
			flags_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			flags_q     <= flags_d;
			if (wr_en) begin
				stamp_vld_q[wr_addr] <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (pop_item.op == OP_SCAN) begin
							state_q    <= ST_SCAN;
							scan_idx_q <= '0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last compare lands here
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (pop_item.op != OP_SCAN)) begin
			offline_mask_q <= show_mask(flags_q);
		end else if (state_q == ST_DRAIN) begin
			offline_mask_q <= show_mask(flags_d);
		end
	end

`ifndef SYNTH
	a_no_result_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result register busy during scan");

	a_flags_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(flags_q))
		else $error("offline flags changed outside a scan");

	a_drain_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (rd_valid_s1 && (rd_idx_s1 == LAST_IDX)))
		else $error("scan ended before the last module was compared");
`endif

endmodule

@@ rtl/core/multi_channel_heartbeat_watchdog_core.sv @@
// heartbeat beat: front, queue, result regs; one beat per cycle while output drains, back idle
// scan beat: the back walks ST_SCAN then ST_DRAIN to the result; one shared subtractor
//   compares one stored stamp per cycle, and the back pops no new beat until the scan ends
// a 2-entry queue lets the input take beats while the back is busy scanning
// reset: stamps read as zero, offline flags clear, timeouts 500 and 2000 ms
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_core
// lost-heartbeat monitor for a set of modules with apb timeout registers
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_core #(
	parameter int NUM_MODULES = mchw_pkg::NUM_MODULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [mchw_pkg::IDX_IN_W-1:0] module_index,
	input  logic [mchw_pkg::TIME_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mchw_pkg::MASK_W-1:0]   offline_mask
);
	import mchw_pkg::*;

	logic [TIME_W-1:0] general_timeout_q;
	logic [TIME_W-1:0] host_timeout_q;
	logic              cfg_wr;
	q_status_t         q_status;
	logic              push;
	item_t             push_item;
	logic              pop;
	item_t             pop_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HOST_TIMEOUT) ? host_timeout_q : general_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			general_timeout_q <= GENERAL_TIMEOUT_RST;
			host_timeout_q    <= HOST_TIMEOUT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_GENERAL_TIMEOUT) begin
				general_timeout_q <= pwdata;
			end else begin
				host_timeout_q <= pwdata;
			end
		end
	end

	mchw_front #(
		.NUM_MODULES (NUM_MODULES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.module_index (module_index),
		.now_ms       (now_ms),
		.q_status     (q_status),
		.push         (push),
		.push_item    (push_item)
	);

	mchw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_status  (q_status)
	);

	mchw_back #(
		.NUM_MODULES (NUM_MODULES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_status        (q_status),
		.pop_item        (pop_item),
		.pop             (pop),
		.general_timeout (general_timeout_q),
		.host_timeout    (host_timeout_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.offline_mask    (offline_mask)
	);

endmodule
